FILE: rtl/dpwd_pkg.sv
// Shared types and constants for the digitizer packet word decoder.
// Used by the front, queue and back modules; depends on nothing.
package dpwd_pkg;

  localparam logic [31:0] MODULE_MARK = 32'ha000ffff;

  localparam logic [3:0] TAG_ADDR      = 4'h1;
  localparam logic [3:0] TAG_WAVE      = 4'h3;
  localparam logic [3:0] TAG_HDR_FIRST = 4'h8;
  localparam logic [3:0] TAG_HDR_REST  = 4'h9;
  localparam logic [3:0] TAG_CKSUM     = 4'hb;
  localparam logic [3:0] TAG_PREPOST   = 4'he;

  localparam logic [3:0] KIND_EVT     = 4'd0;
  localparam logic [3:0] KIND_CLOCK   = 4'd1;
  localparam logic [3:0] KIND_MODADDR = 4'd2;
  localparam logic [3:0] KIND_SLOT    = 4'd3;
  localparam logic [3:0] KIND_SAMPLE  = 4'd6;
  localparam logic [3:0] KIND_PREPOST = 4'd7;
  localparam logic [3:0] KIND_CKMSB   = 4'd8;
  localparam logic [3:0] KIND_CKLSB   = 4'd9;
  localparam logic [3:0] KIND_ERROR   = 4'd10;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_BAD_TAG    = 3'd1;
  localparam logic [2:0] ERR_SHORT      = 3'd2;
  localparam logic [2:0] ERR_TOO_MANY   = 3'd3;
  localparam logic [2:0] ERR_WAVE_TAG   = 3'd4;
  localparam logic [2:0] ERR_MOD_MISMATCH = 3'd5;

  localparam logic [4:0] NUM_SAMPLES_RESET = 5'd12;
  localparam int HEADER_WORDS = 5;
  localparam int MAX_RES = 3;

  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  typedef struct packed {
    logic [3:0]  kind;
    logic [2:0]  error_code;
    logic [2:0]  module_res;
    logic [8:0]  channel;
    logic [4:0]  sample_index;
    logic [31:0] value_a;
    logic [13:0] value_b;
    logic        suppressed;
  } rec_t;

  // All results caused by one input word; cnt is 1 to 3 for a queued bundle.
  typedef struct packed {
    logic [1:0]         cnt;
    rec_t [MAX_RES-1:0] rec;
  } bundle_t;

  function automatic rec_t mk_rec(input logic [3:0] kind, input logic [2:0] err,
                                  input logic [2:0] mod, input logic [8:0] ch,
                                  input logic [4:0] si, input logic [31:0] va,
                                  input logic [13:0] vb, input logic sup);
    rec_t r;
    r.kind         = kind;
    r.error_code   = err;
    r.module_res   = mod;
    r.channel      = ch;
    r.sample_index = si;
    r.value_a      = va;
    r.value_b      = vb;
    r.suppressed   = sup;
    return r;
  endfunction

endpackage

FILE: rtl/dpwd_front.sv
// Front end: accepts packet words, tracks the packet state and builds the
// bundle of results for each word. Depends on dpwd_pkg.
module dpwd_front #(
  parameter int NUM_MODULES = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        word,
  input  logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [4:0]         cfg_data,
  output logic               push,
  output dpwd_pkg::bundle_t  push_data,
  input  logic               full
);
  import dpwd_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER, PH_HEADER_BAD, PH_SCAN, PH_MODHDR, PH_BODY, PH_WAVE, PH_HALT
  } phase_t;

  logic [4:0]  num_samples;
  logic [2:0]  word_count, word_count_next;
  logic [15:0] hw [HEADER_WORDS];
  logic [15:0] hw_next [HEADER_WORDS];
  phase_t      phase, phase_next;
  logic [1:0]  mhp, mhp_next;
  logic [2:0]  module_count, module_count_next;
  logic [2:0]  current_module, current_module_next;
  logic [8:0]  channel_counter, channel_counter_next;
  logic [8:0]  wave_channel, wave_channel_next;
  logic [4:0]  sample_pos, sample_pos_next;
  logic [4:0]  wwl, wwl_next;
  logic        parity_seen, parity_seen_next;
  logic        wave_pending, wave_pending_next;

  logic [1:0]         n;
  rec_t [MAX_RES-1:0] recs;
  logic [3:0]  tag;
  logic [3:0]  want;
  logic        run_packet;
  logic        do_wave;
  logic        body_close;
  logic [2:0]  mod;
  logic [8:0]  ch;
  logic [5:0]  p1;
  logic        accept;

  assign tag       = word[31:28];
  assign in_ready  = !full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  always_comb begin
    word_count_next      = word_count;
    hw_next              = hw;
    phase_next           = phase;
    mhp_next             = mhp;
    module_count_next    = module_count;
    current_module_next  = current_module;
    channel_counter_next = channel_counter;
    wave_channel_next    = wave_channel;
    sample_pos_next      = sample_pos;
    wwl_next             = wwl;
    parity_seen_next     = parity_seen;
    wave_pending_next    = wave_pending;
    n          = 2'd0;
    recs       = '0;
    want       = TAG_HDR_REST;
    run_packet = 1'b0;
    do_wave    = 1'b0;
    body_close = 1'b0;
    mod        = word[8:6];
    ch         = {word[8:6], word[5:0]};
    p1         = {1'b0, sample_pos} + 6'd1;

    if (phase == PH_HEADER || phase == PH_HEADER_BAD) begin
      if (word_count < 3'(HEADER_WORDS)) begin
        want = (word_count == 3'd0) ? TAG_HDR_FIRST : TAG_HDR_REST;
        hw_next[word_count] = word[15:0];
        if (tag != want) phase_next = PH_HEADER_BAD;
        word_count_next = word_count + 3'd1;
        if (last) begin
          recs[n] = mk_rec(KIND_ERROR, ERR_SHORT, 3'd0, 9'd0, 5'd0, word, 14'd0, 1'b0);
          n = n + 2'd1;
        end
      end else if (phase == PH_HEADER_BAD) begin
        recs[n] = mk_rec(KIND_ERROR, ERR_BAD_TAG, 3'd0, 9'd0, 5'd0, word, 14'd0, 1'b0);
        n = n + 2'd1;
        phase_next = PH_HALT;
      end else begin
        recs[0] = mk_rec(KIND_EVT, ERR_NONE, 3'd0, 9'd0, 5'd0, {hw[2], hw[0]}, 14'd0, 1'b0);
        recs[1] = mk_rec(KIND_CLOCK, ERR_NONE, 3'd0, 9'd0, 5'd0, {hw[1], hw[4]}, 14'd0,
                         1'b0);
        recs[2] = mk_rec(KIND_MODADDR, ERR_NONE, 3'd0, 9'd0, 5'd0, {16'd0, hw[3]}, 14'd0,
                         1'b0);
        n = 2'd3;
        phase_next = PH_SCAN;
        run_packet = 1'b1;
      end
    end else if (phase != PH_HALT) begin
      run_packet = 1'b1;
    end

    if (run_packet) begin
      case (phase_next)
        PH_SCAN: begin
          if (word == MODULE_MARK) begin
            phase_next           = PH_MODHDR;
            mhp_next             = 2'd0;
            current_module_next  = module_count;
            channel_counter_next = {module_count, 6'd0};
            parity_seen_next     = 1'b0;
            wave_pending_next    = 1'b0;
            sample_pos_next      = 5'd0;
          end
        end
        PH_MODHDR: begin
          if (n != 2'd3) begin
            recs[n] = mk_rec(KIND_SLOT + {2'd0, mhp}, ERR_NONE, module_count, 9'd0, 5'd0,
                             {16'd0, word[15:0]}, 14'd0, 1'b0);
            n = n + 2'd1;
          end
          mhp_next = mhp + 2'd1;
          if (mhp_next == 2'd3) phase_next = PH_BODY;
        end
        PH_WAVE: begin
          do_wave = 1'b1;
        end
        PH_BODY: begin
          wave_pending_next = 1'b0;
          if (wave_pending && tag == TAG_WAVE) begin
            phase_next = PH_WAVE;
            wwl_next   = {1'b0, num_samples[4:1]} + 5'd1;
            do_wave    = 1'b1;
          end else begin
            case (tag)
              TAG_PREPOST: begin
                if (n != 2'd3) begin
                  recs[n] = mk_rec(KIND_PREPOST, ERR_NONE, current_module,
                                   channel_counter ^ 9'd1, 5'd0, {18'd0, word[13:0]},
                                   word[27:14], 1'b1);
                  n = n + 2'd1;
                end
                channel_counter_next = channel_counter + 9'd1;
              end
              TAG_ADDR: begin
                current_module_next = mod;
                if (mod != module_count || {1'b0, mod} >= 4'(NUM_MODULES)) begin
                  if (n != 2'd3) begin
                    recs[n] = mk_rec(KIND_ERROR, ERR_MOD_MISMATCH, mod, 9'd0, 5'd0, word,
                                     14'd0, 1'b0);
                    n = n + 2'd1;
                  end
                end
                sample_pos_next      = 5'd0;
                parity_seen_next     = 1'b0;
                wave_channel_next    = ch ^ 9'd1;
                channel_counter_next = ch + 9'd1;
                wave_pending_next    = 1'b1;
              end
              TAG_CKSUM: begin
                if (n != 2'd3) begin
                  recs[n] = mk_rec(parity_seen ? KIND_CKLSB : KIND_CKMSB, ERR_NONE,
                                   current_module, 9'd0, 5'd0, {16'd0, word[15:0]},
                                   14'd0, 1'b0);
                  n = n + 2'd1;
                end
                if (!parity_seen) parity_seen_next = 1'b1;
                else body_close = 1'b1;
              end
              default: begin
                // Unknown body words are skipped.
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end

    if (do_wave) begin
      case (tag)
        TAG_WAVE: begin
          if (sample_pos < num_samples && n != 2'd3) begin
            recs[n] = mk_rec(KIND_SAMPLE, ERR_NONE, current_module, wave_channel,
                             sample_pos, {18'd0, word[13:0]}, 14'd0, 1'b0);
            n = n + 2'd1;
          end
          if (p1 < {1'b0, num_samples} && n != 2'd3) begin
            recs[n] = mk_rec(KIND_SAMPLE, ERR_NONE, current_module, wave_channel,
                             p1[4:0], {18'd0, word[27:14]}, 14'd0, 1'b0);
            n = n + 2'd1;
          end
          sample_pos_next = sample_pos + 5'd2;
        end
        TAG_PREPOST: begin
          if (n != 2'd3) begin
            recs[n] = mk_rec(KIND_PREPOST, ERR_NONE, current_module, wave_channel, 5'd0,
                             {18'd0, word[13:0]}, word[27:14], 1'b0);
            n = n + 2'd1;
          end
        end
        default: begin
          if (n != 2'd3) begin
            recs[n] = mk_rec(KIND_ERROR, ERR_WAVE_TAG, current_module, 9'd0, 5'd0, word,
                             14'd0, 1'b0);
            n = n + 2'd1;
          end
        end
      endcase
      wwl_next = wwl_next - 5'd1;
      if (wwl_next == 5'd0) phase_next = PH_BODY;
    end

    // A module closes on its second checksum word or when the packet ends inside it.
    if (body_close || (last && (phase_next inside {PH_MODHDR, PH_BODY, PH_WAVE}))) begin
      if ({1'b0, module_count} + 4'd1 >= 4'(NUM_MODULES)) begin
        if (n != 2'd3) begin
          recs[n] = mk_rec(KIND_ERROR, ERR_TOO_MANY, module_count, 9'd0, 5'd0, word,
                           14'd0, 1'b0);
          n = n + 2'd1;
        end
        phase_next = PH_HALT;
      end else begin
        phase_next = PH_SCAN;
      end
      module_count_next = module_count + 3'd1;
    end

    if (last) begin
      word_count_next = 3'd0;
      for (int i = 0; i < HEADER_WORDS; i++) hw_next[i] = 16'd0;
      phase_next           = PH_HEADER;
      mhp_next             = 2'd0;
      module_count_next    = 3'd0;
      current_module_next  = 3'd0;
      channel_counter_next = 9'd0;
      wave_channel_next    = 9'd0;
      sample_pos_next      = 5'd0;
      wwl_next             = 5'd0;
      parity_seen_next     = 1'b0;
      wave_pending_next    = 1'b0;
    end
  end

  assign push          = accept && (n != 2'd0);
  assign push_data.cnt = n;
  assign push_data.rec = recs;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_samples     <= NUM_SAMPLES_RESET;
      word_count      <= 3'd0;
      for (int i = 0; i < HEADER_WORDS; i++) hw[i] <= 16'd0;
      phase           <= PH_HEADER;
      mhp             <= 2'd0;
      module_count    <= 3'd0;
      current_module  <= 3'd0;
      channel_counter <= 9'd0;
      wave_channel    <= 9'd0;
      sample_pos      <= 5'd0;
      wwl             <= 5'd0;
      parity_seen     <= 1'b0;
      wave_pending    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) num_samples <= cfg_data;
      if (accept) begin
        word_count      <= word_count_next;
        hw              <= hw_next;
        phase           <= phase_next;
        mhp             <= mhp_next;
        module_count    <= module_count_next;
        current_module  <= current_module_next;
        channel_counter <= channel_counter_next;
        wave_channel    <= wave_channel_next;
        sample_pos      <= sample_pos_next;
        wwl             <= wwl_next;
        parity_seen     <= parity_seen_next;
        wave_pending    <= wave_pending_next;
      end
    end
  end

endmodule

FILE: rtl/dpwd_queue.sv
// Short queue of result bundles between the front and back ends.
// Depends on dpwd_pkg.
module dpwd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  dpwd_pkg::bundle_t  push_data,
  output logic               full,
  input  logic               pop,
  output dpwd_pkg::bundle_t  head,
  output logic               empty
);
  import dpwd_pkg::*;

  bundle_t             slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full  = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

FILE: rtl/dpwd_back.sv
// Back end: sends the results of each queued bundle one per transfer through
// an output register. Depends on dpwd_pkg.
module dpwd_back (
  input  logic               clk,
  input  logic               rst,
  input  dpwd_pkg::bundle_t  head,
  input  logic               empty,
  output logic               pop,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [71:0]        m_axis_tdata,
  output logic [3:0]         m_axis_tuser,
  output logic               m_axis_tlast
);
  import dpwd_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       head_last;
  rec_t       out_rec;

  assign load      = !empty && (!m_axis_tvalid || m_axis_tready);
  assign head_last = (idx == head.cnt - 2'd1);
  assign pop       = load && head_last;

  assign m_axis_tuser = out_rec.kind;
  assign m_axis_tdata = {5'd0, out_rec.suppressed, out_rec.value_b, out_rec.value_a,
                         out_rec.sample_index, out_rec.channel, out_rec.module_res,
                         out_rec.error_code};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      idx           <= 2'd0;
    end else begin
      if (load) begin
        m_axis_tvalid <= 1'b1;
        idx           <= head_last ? 2'd0 : idx + 2'd1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_rec      <= head.rec[idx];
      m_axis_tlast <= head_last;
    end
  end

endmodule

FILE: rtl/digitizer_packet_word_decoder_core.sv
// Digitizer packet word decoder, top level. Words are taken at one per clock
// while the result queue has room; results pass through the queue and the
// output register and leave at one per clock while m_axis_tready is high,
// so a word with k results takes k transfers (the output port is the limit).
// Synchronous reset returns the packet state to the header, empties the queue
// and sets num_samples to 12. Uses dpwd_front, dpwd_queue, dpwd_back.
module digitizer_packet_word_decoder_core #(
  parameter int NUM_MODULES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // word[31:0]
  input  logic        s_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,      // num_samples
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // error_code[2:0], module_res[5:3], channel[14:6], sample_index[19:15],
  // value_a[51:20], value_b[65:52], suppressed[66], zero[71:67]
  output logic [71:0] m_axis_tdata,
  output logic [3:0]  m_axis_tuser,  // kind[3:0]
  output logic        m_axis_tlast
);
  import dpwd_pkg::*;

  logic    push;
  bundle_t push_data;
  logic    full;
  logic    pop;
  bundle_t head;
  logic    empty;

  dpwd_front #(
    .NUM_MODULES(NUM_MODULES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .word      (s_axis_tdata),
    .last      (s_axis_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  dpwd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  dpwd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (empty),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
